### rtl/ppf_pkg.sv
`timescale 1ns / 1ps

package ppf_pkg;

    localparam int unsigned PAGE_BYTES_DEF = 256;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    localparam logic [7:0] SYNC_BYTE_RESET = 8'hEF;
    localparam logic [7:0] PAD_VALUE_RESET = 8'hFF;

    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 8;
    localparam logic [CFG_INDEX_W-1:0] REG_SYNC_BYTE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PAD_VALUE = 2'd1;

    localparam logic MODE_OPEN = 1'b0;
    localparam logic MODE_NEXT = 1'b1;

    typedef struct packed {
        logic       mode;
        logic [7:0] kind;
        logic [8:0] pay_len;
        logic [7:0] payload_byte;
    } ppf_in_t;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       consumed;
        logic       last_of_frame;
        logic       no_frame_error;
    } ppf_out_t;

    // CRC-16/CCITT-FALSE update by one byte, most significant bit first.
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

### rtl/page_packet_framer_crc16.sv
`timescale 1ns / 1ps

// Pull-driven packet framer with a CRC-16/CCITT-FALSE check. A start item opens a frame and
// returns the start code; each following item returns the next frame byte: type, length low,
// length high, PAGE_BYTES payload bytes (supplied bytes while below the length, then the pad
// value) and the CRC low and high bytes, PAGE_BYTES + 6 bytes in all. The block takes one item
// per cycle while results are taken: an input register feeds a single byte-wide CRC update whose
// result is held in an output register and offered on the result channel from there; the input
// register can still take one more item while a result waits.
module page_packet_framer_crc16 #(
    parameter int unsigned PAGE_BYTES = ppf_pkg::PAGE_BYTES_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [ppf_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [ppf_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  ppf_pkg::ppf_in_t                s_item,
    output logic                            m_valid,
    input  logic                            m_ready,
    output ppf_pkg::ppf_out_t               m_item
);
    import ppf_pkg::*;

    logic      in_valid_reg, in_valid_next;
    ppf_in_t   in_item_reg;
    logic      out_valid_reg, out_valid_next;
    ppf_out_t  out_item_reg;
    ppf_out_t  step_result;
    logic      advance;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_item;
        end
        if (advance) begin
            out_item_reg <= step_result;
        end
    end

    ppf_engine #(
        .PAGE_BYTES (PAGE_BYTES)
    ) u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .fire      (advance),
        .item      (in_item_reg),
        .result    (step_result)
    );

    assign m_valid = out_valid_reg;
    assign m_item  = out_item_reg;

endmodule

### rtl/ppf_engine.sv
`timescale 1ns / 1ps

module ppf_engine #(
    parameter int unsigned PAGE_BYTES = ppf_pkg::PAGE_BYTES_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [ppf_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [ppf_pkg::CFG_DATA_W-1:0]       cfg_wdata,
    input  logic                                 fire,
    input  ppf_pkg::ppf_in_t                     item,
    output ppf_pkg::ppf_out_t                    result
);
    import ppf_pkg::*;

    localparam int unsigned IW  = $clog2(PAGE_BYTES + 6);
    localparam int unsigned CW  = (IW > 9) ? IW : 9;
    localparam int unsigned SAT = (PAGE_BYTES > 511) ? 511 : PAGE_BYTES;

    localparam logic [IW-1:0] IDX_TYPE   = IW'(1);
    localparam logic [IW-1:0] IDX_LEN_LO = IW'(2);
    localparam logic [IW-1:0] IDX_LEN_HI = IW'(3);
    localparam logic [IW-1:0] IDX_DATA   = IW'(4);
    localparam logic [IW-1:0] IDX_CRC_LO = IW'(4 + PAGE_BYTES);

    logic [7:0]    sync_byte_reg;
    logic [7:0]    pad_value_reg;
    logic [IW-1:0] frame_index_reg, frame_index_next;
    logic [15:0]   running_crc_reg, running_crc_next;
    logic [7:0]    held_type_reg, held_type_next;
    logic [8:0]    held_length_reg, held_length_next;
    logic          frame_open_reg, frame_open_next;

    logic [IW-1:0] data_pos;
    logic [CW-1:0] pos_ext;
    logic [CW-1:0] len_ext;
    logic          add_crc;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sync_byte_reg <= SYNC_BYTE_RESET;
            pad_value_reg <= PAD_VALUE_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_SYNC_BYTE: sync_byte_reg <= cfg_wdata[7:0];
                REG_PAD_VALUE: pad_value_reg <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        frame_index_next = frame_index_reg;
        running_crc_next = running_crc_reg;
        held_type_next   = held_type_reg;
        held_length_next = held_length_reg;
        frame_open_next  = frame_open_reg;
        result           = '0;
        add_crc          = 1'b0;
        data_pos         = frame_index_reg - IDX_DATA;
        pos_ext          = CW'(data_pos);
        len_ext          = CW'(held_length_reg);

        if (item.mode == MODE_OPEN) begin
            held_type_next   = item.kind;
            held_length_next = (item.pay_len > 9'(SAT)) ? 9'(SAT) : item.pay_len;
            running_crc_next = CRC_INIT;
            frame_index_next = IDX_TYPE;
            frame_open_next  = 1'b1;
            result.frame_byte = sync_byte_reg;
        end else if (!frame_open_reg) begin
            result.no_frame_error = 1'b1;
        end else begin
            add_crc = 1'b1;
            if (frame_index_reg == IDX_TYPE) begin
                result.frame_byte = held_type_reg;
            end else if (frame_index_reg == IDX_LEN_LO) begin
                result.frame_byte = held_length_reg[7:0];
            end else if (frame_index_reg == IDX_LEN_HI) begin
                result.frame_byte = {7'd0, held_length_reg[8]};
            end else if (frame_index_reg < IDX_CRC_LO) begin
                if (pos_ext < len_ext) begin
                    result.frame_byte = item.payload_byte;
                    result.consumed   = 1'b1;
                end else begin
                    result.frame_byte = pad_value_reg;
                end
            end else if (frame_index_reg == IDX_CRC_LO) begin
                result.frame_byte = running_crc_reg[7:0];
                add_crc           = 1'b0;
            end else begin
                result.frame_byte    = running_crc_reg[15:8];
                result.last_of_frame = 1'b1;
                add_crc              = 1'b0;
            end

            if (add_crc) begin
                running_crc_next = crc_byte(running_crc_reg, result.frame_byte);
            end
            if (result.last_of_frame) begin
                frame_open_next  = 1'b0;
                frame_index_next = '0;
            end else begin
                frame_index_next = frame_index_reg + IW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_index_reg <= '0;
            running_crc_reg <= CRC_INIT;
            held_type_reg   <= '0;
            held_length_reg <= '0;
            frame_open_reg  <= 1'b0;
        end else if (fire) begin
            frame_index_reg <= frame_index_next;
            running_crc_reg <= running_crc_next;
            held_type_reg   <= held_type_next;
            held_length_reg <= held_length_next;
            frame_open_reg  <= frame_open_next;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        !frame_open_reg |-> frame_index_reg == '0)
        else $error("Frame index is not zero while no frame is open.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        fire && item.mode == MODE_OPEN |=> frame_open_reg && frame_index_reg == IDX_TYPE
            && running_crc_reg == CRC_INIT)
        else $error("Opening a frame did not restart the index and the CRC.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        fire && item.mode == MODE_NEXT && !frame_open_reg
            |=> $stable(frame_index_reg) && $stable(running_crc_reg) && !frame_open_reg)
        else $error("A request with no open frame changed the frame state.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        fire && result.last_of_frame |=> !frame_open_reg)
        else $error("The frame stayed open after its last byte.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        fire |-> !(result.consumed && (result.last_of_frame || result.no_frame_error)))
        else $error("A payload byte was taken outside the payload field.");

endmodule

### dv/framer_byte_checker.sv
`timescale 1ns / 1ps

module framer_byte_checker #(
    parameter int unsigned PAGE_BYTES = ppf_pkg::PAGE_BYTES_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [ppf_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [ppf_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                            s_valid,
    input  logic                            s_ready,
    input  ppf_pkg::ppf_in_t                s_item,
    input  logic                            m_valid,
    input  logic                            m_ready,
    input  ppf_pkg::ppf_out_t               m_item,
    output int unsigned                     fail_count,
    output int unsigned                     bytes_owed
);
    import ppf_pkg::*;

    logic [7:0]  start_byte;
    logic [7:0]  pad_byte;
    logic [8:0]  next_pos;
    logic [15:0] frame_crc;
    logic [7:0]  kept_type;
    logic [8:0]  kept_len;
    logic        frame_live;
    ppf_out_t    bytes_due[$];
    int unsigned mismatches = 0;
    int unsigned owed = 0;

    assign fail_count = mismatches;
    assign bytes_owed = owed;

    function automatic logic [15:0] crc_ccitt_step(input logic [15:0] crc,
                                                   input logic [7:0] data);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int i = 7; i >= 0; i--) begin
            fb = c[15] ^ data[i];
            c = {c[14:0], 1'b0};
            if (fb) begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

    function automatic ppf_out_t frame_byte_for(input ppf_in_t it);
        ppf_out_t   r;
        logic [8:0] pos;
        logic       add_crc;
        r = '0;
        if (it.mode == MODE_OPEN) begin
            kept_type = it.kind;
            kept_len = (it.pay_len > PAGE_BYTES) ? 9'(PAGE_BYTES) : it.pay_len;
            frame_crc = CRC_INIT;
            next_pos = 9'd1;
            frame_live = 1'b1;
            r.frame_byte = start_byte;
        end else if (!frame_live) begin
            r.no_frame_error = 1'b1;
        end else begin
            pos = next_pos;
            add_crc = 1'b1;
            if (pos == 9'd1) begin
                r.frame_byte = kept_type;
            end else if (pos == 9'd2) begin
                r.frame_byte = kept_len[7:0];
            end else if (pos == 9'd3) begin
                r.frame_byte = {7'd0, kept_len[8]};
            end else if (pos < PAGE_BYTES + 4) begin
                if (pos - 9'd4 < kept_len) begin
                    r.frame_byte = it.payload_byte;
                    r.consumed = 1'b1;
                end else begin
                    r.frame_byte = pad_byte;
                end
            end else if (pos == PAGE_BYTES + 4) begin
                r.frame_byte = frame_crc[7:0];
                add_crc = 1'b0;
            end else begin
                r.frame_byte = frame_crc[15:8];
                r.last_of_frame = 1'b1;
                add_crc = 1'b0;
            end
            if (add_crc) begin
                frame_crc = crc_ccitt_step(frame_crc, r.frame_byte);
            end
            if (r.last_of_frame) begin
                frame_live = 1'b0;
                next_pos = 9'd0;
            end else begin
                next_pos = pos + 9'd1;
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t: mismatch: %s", $time, msg);
        mismatches++;
    endtask

    always @(posedge aclk) begin
        ppf_out_t want;
        if (!aresetn) begin
            start_byte = SYNC_BYTE_RESET;
            pad_byte = PAD_VALUE_RESET;
            next_pos = '0;
            frame_crc = CRC_INIT;
            kept_type = '0;
            kept_len = '0;
            frame_live = 1'b0;
            bytes_due.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_SYNC_BYTE: start_byte = cfg_wdata;
                    REG_PAD_VALUE: pad_byte = cfg_wdata;
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (bytes_due.size() == 0) begin
                    report_mismatch($sformatf("result %h arrived with nothing owed", m_item));
                end else begin
                    want = bytes_due.pop_front();
                    if (m_item.frame_byte !== want.frame_byte) begin
                        report_mismatch($sformatf("frame_byte %h, expected %h",
                                                  m_item.frame_byte, want.frame_byte));
                    end
                    if (m_item.consumed !== want.consumed) begin
                        report_mismatch($sformatf("consumed %b, expected %b",
                                                  m_item.consumed, want.consumed));
                    end
                    if (m_item.last_of_frame !== want.last_of_frame) begin
                        report_mismatch($sformatf("last_of_frame %b, expected %b",
                                                  m_item.last_of_frame, want.last_of_frame));
                    end
                    if (m_item.no_frame_error !== want.no_frame_error) begin
                        report_mismatch($sformatf("no_frame_error %b, expected %b",
                                                  m_item.no_frame_error, want.no_frame_error));
                    end
                end
            end
            if (s_valid && s_ready) begin
                bytes_due.push_back(frame_byte_for(s_item));
            end
        end
        owed = bytes_due.size();
    end

endmodule

### dv/tb_page_packet_framer_crc16.sv
`timescale 1ns / 1ps

module tb_page_packet_framer_crc16;
    import ppf_pkg::*;

    localparam int unsigned PAGE = PAGE_BYTES_DEF;
    localparam int unsigned FULL_FRAME_NEXTS = PAGE + 5;
    localparam int unsigned STALL_LIMIT = 2000;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 2'd3;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    ppf_in_t                s_item = '0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    ppf_out_t               m_item;
    int unsigned            fail_count;
    int unsigned            bytes_owed;
    logic                   steady = 1'b0;

    always #6 aclk = ~aclk;

    page_packet_framer_crc16 #(
        .PAGE_BYTES(PAGE)
    ) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item)
    );

    framer_byte_checker #(
        .PAGE_BYTES(PAGE)
    ) u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_item     (m_item),
        .fail_count (fail_count),
        .bytes_owed (bytes_owed)
    );

    always @(negedge aclk) begin
        m_ready <= steady || ($urandom_range(0, 99) >= 7);
    end

    function automatic ppf_in_t make_item(input logic mode, input logic [7:0] kind,
                                          input logic [8:0] pay_len,
                                          input logic [7:0] payload_byte);
        ppf_in_t it;
        it.mode = mode;
        it.kind = kind;
        it.pay_len = pay_len;
        it.payload_byte = payload_byte;
        return it;
    endfunction

    function automatic logic [8:0] pick_length();
        case ($urandom_range(0, 4))
            0: return 9'd0;
            1: return 9'($urandom_range(1, 16));
            2: return 9'($urandom_range(240, 256));
            3: return 9'($urandom_range(257, 511));
            default: return 9'($urandom_range(0, 511));
        endcase
    endfunction

    task automatic send_item(input ppf_in_t it);
        @(negedge aclk);
        while (!steady && $urandom_range(0, 99) < 7) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_item <= it;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
    endtask

    task automatic send_next();
        send_item(make_item(MODE_NEXT, 8'($urandom), 9'($urandom), 8'($urandom)));
    endtask

    task automatic wait_for_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (bytes_owed != 0) begin
            @(negedge aclk);
        end
    endtask

    task automatic send_frame(input int unsigned nexts, input int pause_at);
        send_item(make_item(MODE_OPEN, 8'($urandom), pick_length(), 8'($urandom)));
        for (int i = 0; i < nexts; i++) begin
            send_next();
            if (i == pause_at) begin
                wait_for_results();
            end
        end
    endtask

    task automatic mixed_traffic(input int unsigned count);
        int unsigned sent;
        logic [31:0] r;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(0, 99) < 60) begin
                r = $urandom_range(0, 40);
                send_frame(r, -1);
                sent += r + 1;
            end else begin
                r = $urandom_range(1, 8);
                repeat (r) begin
                    send_item(ppf_in_t'(26'($urandom)));
                end
                sent += r;
            end
        end
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] value);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_registers(input logic [7:0] sync_byte, input logic [7:0] pad_value);
        wait_for_results();
        repeat (3) @(negedge aclk);
        write_reg(REG_SYNC_BYTE, sync_byte);
        write_reg(REG_PAD_VALUE, pad_value);
    endtask

    initial begin : watchdog
        int unsigned idle_cycles;
        idle_cycles = 0;
        @(posedge aresetn);
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("Watchdog: no item moved for %0d cycles.", STALL_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;

        send_item(make_item(MODE_NEXT, 8'h00, 9'h000, 8'h00));
        send_item(make_item(MODE_NEXT, 8'hFF, 9'h1FF, 8'hFF));
        send_item(make_item(MODE_OPEN, 8'h00, 9'h1FF, 8'h00));
        repeat (3) send_next();
        send_item(make_item(MODE_NEXT, 8'hFF, 9'h1FF, 8'h00));
        send_item(make_item(MODE_NEXT, 8'h00, 9'h000, 8'hFF));
        send_item(make_item(MODE_OPEN, 8'hFF, 9'h000, 8'hFF));
        repeat (5) send_next();
        send_item(make_item(MODE_OPEN, 8'hA5, 9'd256, 8'h5A));
        repeat (3) send_next();
        send_item(make_item(MODE_OPEN, 8'h3C, 9'd257, 8'h00));
        repeat (2) send_next();
        send_item(make_item(MODE_OPEN, 8'h81, 9'd1, 8'h00));
        repeat (5) send_next();

        set_registers(8'h00, 8'h00);
        mixed_traffic(30);
        mixed_traffic(15);

        set_registers(8'hFF, 8'hFF);
        steady = 1'b1;
        send_frame(FULL_FRAME_NEXTS, 100);
        steady = 1'b0;
        mixed_traffic(30);

        set_registers(8'($urandom), 8'($urandom));
        write_reg(REG_SPARE, 8'($urandom));
        mixed_traffic(60);

        wait_for_results();
        repeat (8) @(negedge aclk);
        if (fail_count == 0 && bytes_owed == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

### sim.f
rtl/ppf_pkg.sv
rtl/ppf_engine.sv
rtl/page_packet_framer_crc16.sv
dv/framer_byte_checker.sv
dv/tb_page_packet_framer_crc16.sv
